// ===== rtl/llf_pkg.sv =====
// llf_pkg: widths, codes, types and arithmetic helpers for the ladder low-pass filter
// no dependencies; used by llf_front, llf_engine and ladder_lowpass_filter_unit
package llf_pkg;

    // fixed field widths
    localparam int SAMPLE_W       = 16;
    localparam int STAGE_W        = 32;
    localparam int CUT_W          = 15;
    localparam int RES_W          = 17;
    localparam int COEF_FRAC_BITS = 15;
    localparam int NUM_STAGES     = 4;
    localparam int STAGE_IDX_W    = $clog2(NUM_STAGES);

    // input queue between front and engine (power of two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (CUT_W > RES_W) ? CUT_W : RES_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESON  = 1'd1;
    localparam logic [CUT_W-1:0] CUTOFF_RESET = 15'd30000;
    localparam logic [RES_W-1:0] RESON_RESET  = 17'd0;

    // datapath widths, derived from the field widths and the fraction bits
    localparam int FB_W      = RES_W + STAGE_W + 1 - COEF_FRAC_BITS;
    localparam int PREV_BASE = (FB_W > STAGE_W) ? FB_W : STAGE_W;
    localparam int PREV_W    = PREV_BASE + 1;
    localparam int DIFF_W    = PREV_W + 1;
    localparam int MUL_B_W   = CFG_DATA_W + 1;
    localparam int PROD_W    = DIFF_W + MUL_B_W;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } llf_item_t;

    typedef struct packed {
        logic [CUT_W-1:0] cutoff;
        logic [RES_W-1:0] resonance;
    } llf_coef_t;

    // divide by 2^COEF_FRAC_BITS, rounding toward zero
    function automatic logic signed [PROD_W-1:0] scale_down(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] bias;
        bias = '0;
        if (p[PROD_W-1]) begin
            bias = PROD_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
        end
        return (p + bias) >>> COEF_FRAC_BITS;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] saturate(
        input logic signed [STAGE_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > STAGE_W'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (v < STAGE_W'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/llf_front.sv =====
// llf_front: input side of the filter, takes sample beats into a short queue
// depends on llf_pkg
module llf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [llf_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                q_valid,
    input  logic                                q_ready,
    output llf_pkg::llf_item_t                  q_item
);

    llf_pkg::llf_item_t                 slot_reg [llf_pkg::QUEUE_DEPTH];
    logic [llf_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [llf_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [llf_pkg::QUEUE_CW-1:0]       count_reg, count_next;
    logic                               push, pop;

    assign s_ready = (count_reg != llf_pkg::QUEUE_CW'(llf_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].sample <= s_sample_in;
        end
    end

endmodule

// ===== rtl/llf_engine.sv =====
// llf_engine: sequencer with one shared multiplier running the feedback and four stages
// depends on llf_pkg
module llf_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  llf_pkg::llf_item_t                  q_item,
    input  llf_pkg::llf_coef_t                  coef,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [llf_pkg::SAMPLE_W-1:0] m_sample_out
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREV = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_OUT  = 5'b10000
    } llf_state_t;

    llf_state_t                               state_reg, state_next;
    logic [llf_pkg::STAGE_IDX_W-1:0]          idx_reg;
    logic signed [llf_pkg::STAGE_W-1:0]       stage_reg [llf_pkg::NUM_STAGES];
    logic signed [llf_pkg::SAMPLE_W-1:0]      x_reg;
    logic signed [llf_pkg::PREV_W-1:0]        prev_reg;
    logic signed [llf_pkg::PROD_W-1:0]        prod_reg;
    logic                                     m_valid_reg;
    logic signed [llf_pkg::SAMPLE_W-1:0]      out_reg;

    logic signed [llf_pkg::STAGE_W-1:0]       own;
    logic signed [llf_pkg::DIFF_W-1:0]        diff;
    logic signed [llf_pkg::DIFF_W-1:0]        mul_a;
    logic signed [llf_pkg::MUL_B_W-1:0]       mul_b;
    logic signed [llf_pkg::PROD_W-1:0]        prod;
    logic signed [llf_pkg::PROD_W-1:0]        scaled;
    logic signed [llf_pkg::STAGE_W-1:0]       stage_new;
    logic                                     pop;
    logic                                     out_free;

    assign q_ready      = (state_reg == ST_IDLE);
    assign pop          = q_valid && q_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;
    assign out_free     = !m_valid_reg || m_ready;

    assign own  = stage_reg[idx_reg];
    assign diff = llf_pkg::DIFF_W'(prev_reg) - llf_pkg::DIFF_W'(own);

    // idle uses the multiplier for the feedback term, later states for the stages
    always_comb begin
        if (state_reg == ST_IDLE) begin
            mul_a = llf_pkg::DIFF_W'(stage_reg[llf_pkg::NUM_STAGES-1]);
            mul_b = $signed({1'b0, llf_pkg::CFG_DATA_W'(coef.resonance)});
        end else begin
            mul_a = diff;
            mul_b = $signed({1'b0, llf_pkg::CFG_DATA_W'(coef.cutoff)});
        end
    end

    assign prod      = mul_a * mul_b;
    assign scaled    = llf_pkg::scale_down(prod_reg);
    assign stage_new = own + scaled[llf_pkg::STAGE_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_PREV;
                end
            end
            ST_PREV: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (idx_reg == llf_pkg::STAGE_IDX_W'(llf_pkg::NUM_STAGES - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < llf_pkg::NUM_STAGES; i++) begin
                stage_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_PREV) begin
                idx_reg <= '0;
            end
            if (state_reg == ST_ACC) begin
                stage_reg[idx_reg] <= stage_new;
                idx_reg            <= idx_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg <= q_item.sample;
        end
        if (pop || state_reg == ST_MUL) begin
            prod_reg <= prod;
        end
        if (state_reg == ST_PREV) begin
            // input minus scaled feedback
            prev_reg <= llf_pkg::PREV_W'(x_reg) - llf_pkg::PREV_W'(scaled);
        end
        if (state_reg == ST_ACC) begin
            prev_reg <= llf_pkg::PREV_W'(stage_new);
        end
        if (state_reg == ST_OUT && out_free) begin
            out_reg <= llf_pkg::saturate(stage_reg[llf_pkg::NUM_STAGES-1]);
        end
    end

    a_last_stage_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC &&
         idx_reg == llf_pkg::STAGE_IDX_W'(llf_pkg::NUM_STAGES - 1)) |=> state_reg == ST_OUT)
        else $error("engine did not finish after last stage");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> ($past(state_reg) == ST_PREV || $past(state_reg) == ST_ACC))
        else $error("stage multiply out of sequence");

    a_idx_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PREV |=> idx_reg == '0)
        else $error("stage index not cleared before first stage");

endmodule

// ===== rtl/ladder_lowpass_filter_unit.sv =====
// ladder_lowpass_filter_unit: four-pole ladder low-pass filter top level
// depends on llf_pkg, llf_front, llf_engine
//
//  port group | direction | handshake          | payload
//  s_         | in        | s_valid / s_ready  | s_sample_in  (signed 16)
//  m_         | out       | m_valid / m_ready  | m_sample_out (signed 16)
//  cfg_       | in        | cfg_we             | cfg_index, cfg_wdata (17)
//
// each sample runs through the engine as a feedback multiply, a subtract,
// then a multiply and an accumulate for each of the four stages on the one
// shared multiplier, and an output step; the next sample starts after that.
// a two-entry input queue takes beats while the engine is busy, until it is full.
// a stalled result holds the engine in its output step; reset zeroes all stages.
module ladder_lowpass_filter_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [llf_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [llf_pkg::SAMPLE_W-1:0]   m_sample_out,
    input  logic                                  cfg_we,
    input  logic [llf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [llf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    llf_pkg::llf_coef_t  coef_reg;
    llf_pkg::llf_item_t  q_item;
    logic                q_valid;
    logic                q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.cutoff    <= llf_pkg::CUTOFF_RESET;
            coef_reg.resonance <= llf_pkg::RESON_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                llf_pkg::CFG_CUTOFF: coef_reg.cutoff    <= cfg_wdata[llf_pkg::CUT_W-1:0];
                llf_pkg::CFG_RESON:  coef_reg.resonance <= cfg_wdata[llf_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    llf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    llf_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .coef         (coef_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule
